// ===== hw/rtl/ldf_pkg.sv =====
// ldf_pkg: types, constants and helpers for the line difference update framer
// used by every module under hw/rtl except ldf_ram; no dependencies
`default_nettype none
package ldf_pkg;
  localparam int unsigned Rows = 25;
  localparam int unsigned Cols = 80;
  localparam int unsigned Cells = Rows * Cols;
  localparam int unsigned RowW = $clog2(Rows + 1);
  localparam int unsigned ColW = $clog2(Cols + 1);
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [2:0] {
    ReqWriteCell  = 3'd0,
    ReqWriteTable = 3'd1,
    ReqSetCursor  = 3'd2,
    ReqLine       = 3'd3,
    ReqRefresh    = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] value;
    logic [7:0] line_number;
  } in_item_t;

  typedef struct packed {
    logic [4:0] line_num;
    logic [6:0] cursor_pos;
    logic [6:0] start_col;
    logic [6:0] span_count;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [1:0] bytes_valid;
    logic       last;
  } out_item_t;

  // command from front to back
  typedef enum logic [1:0] {
    CmdCell  = 2'd0,
    CmdTable = 2'd1,
    CmdSend  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [RowW-1:0] line;
    logic [7:0]      col;
    logic [7:0]      value;
    logic            force_send;
    logic [6:0]      cpos;
  } cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ldf_ram.sv =====
// ldf_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module ldf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ldf_front.sv =====
// ldf_front: accepts host requests, keeps cursor state, classifies into commands
// depends on ldf_pkg
`default_nettype none
module ldf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ldf_pkg::in_item_t in_data_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_full_i,
  output ldf_pkg::cmd_t          cmd_o
);
  logic [ldf_pkg::RowW-1:0] crow_q, crow_d;
  logic [6:0]               ccol_q, ccol_d;
  logic [ldf_pkg::RowW-1:0] cur_q, cur_d;
  logic [ldf_pkg::RowW-1:0] r_cl;
  logic [6:0]               c_cl;
  logic [ldf_pkg::RowW-1:0] sel_line;
  logic                     acc;

  assign in_stall_o = cmd_full_i;
  assign acc = in_valid_i && !cmd_full_i;

  // clamp cursor position
  always_comb begin
    if (in_data_i.row > 8'(ldf_pkg::Rows)) r_cl = ldf_pkg::RowW'(ldf_pkg::Rows - 1);
    else if (in_data_i.row == 8'd0) r_cl = '0;
    else r_cl = ldf_pkg::RowW'(in_data_i.row - 8'd1);
    if (in_data_i.column > 8'(ldf_pkg::Cols)) c_cl = 7'(ldf_pkg::Cols - 1);
    else if (in_data_i.column == 8'd0) c_cl = '0;
    else c_cl = 7'(in_data_i.column - 8'd1);
  end

  // classify
  always_comb begin
    crow_d = crow_q;
    ccol_d = ccol_q;
    cur_d = cur_q;
    cmd_valid_o = 1'b0;
    sel_line = cur_q;
    cmd_o = '0;
    cmd_o.cmd = ldf_pkg::CmdSend;
    cmd_o.col = in_data_i.column;
    cmd_o.value = in_data_i.value;
    unique case (in_data_i.req_type)
      ldf_pkg::ReqWriteCell: begin
        cmd_o.cmd = ldf_pkg::CmdCell;
        cmd_valid_o = in_valid_i && (in_data_i.row < 8'(ldf_pkg::Rows))
                      && (in_data_i.column < 8'(ldf_pkg::Cols));
        sel_line = ldf_pkg::RowW'(in_data_i.row);
      end
      ldf_pkg::ReqWriteTable: begin
        cmd_o.cmd = ldf_pkg::CmdTable;
        cmd_valid_o = in_valid_i;
      end
      ldf_pkg::ReqSetCursor: begin
        if (r_cl != crow_q || c_cl != ccol_q) begin
          cmd_valid_o = in_valid_i;
          crow_d = r_cl;
          ccol_d = c_cl;
        end
        sel_line = r_cl;
        cmd_o.force_send = 1'b1;
      end
      ldf_pkg::ReqLine: begin
        if (in_data_i.line_number == 8'd0) begin
          cmd_valid_o = in_valid_i && (crow_q != ldf_pkg::RowW'(ldf_pkg::Rows));
          sel_line = crow_q;
          cmd_o.force_send = 1'b1;
        end else if (in_data_i.line_number <= 8'(ldf_pkg::Rows)) begin
          cmd_valid_o = in_valid_i;
          sel_line = ldf_pkg::RowW'(in_data_i.line_number - 8'd1);
          cur_d = sel_line;
        end
      end
      ldf_pkg::ReqRefresh: begin
        cmd_valid_o = in_valid_i && (cur_q < ldf_pkg::RowW'(ldf_pkg::Rows));
      end
      default: ;
    endcase
    cmd_o.line = sel_line;
    if (sel_line == crow_d) cmd_o.cpos = ccol_d + 7'd1;
    if (!acc) begin
      crow_d = crow_q;
      ccol_d = ccol_q;
      cur_d = cur_q;
    end
  end

  // cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crow_q <= ldf_pkg::RowW'(ldf_pkg::Rows);
      ccol_q <= 7'(ldf_pkg::Cols);
      cur_q <= '0;
    end else begin
      crow_q <= crow_d;
      ccol_q <= ccol_d;
      cur_q <= cur_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ldf_queue.sv =====
// ldf_queue: short command queue between front and back
// depends on ldf_pkg
`default_nettype none
module ldf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ldf_pkg::cmd_t push_data_i,
  output logic               full_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output ldf_pkg::cmd_t      pop_data_o
);
  ldf_pkg::cmd_t              buf_q [ldf_pkg::QDepth];
  logic [ldf_pkg::QPtrW-1:0]  wp_q, rp_q;
  logic [ldf_pkg::QPtrW:0]    cnt_q;
  logic                       do_push, do_pop;

  assign full_o = cnt_q == (ldf_pkg::QPtrW + 1)'(ldf_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pop_data_o = buf_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= push_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (ldf_pkg::QPtrW + 1)'(do_push) - (ldf_pkg::QPtrW + 1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ldf_back.sv =====
// ldf_back: executes commands: screen and table writes, diff scan and framing
// depends on ldf_pkg and ldf_ram
`default_nettype none
module ldf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  wire ldf_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ldf_pkg::out_item_t  out_data_o
);
  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StEndRd = 9'b000000100,
    StEndCk = 9'b000001000,
    StStRd  = 9'b000010000,
    StStCk  = 9'b000100000,
    StCpRd  = 9'b001000000,
    StCpWr  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  ldf_pkg::cmd_t cmd_q, cmd_d;
  logic [ldf_pkg::AddrW-1:0] clr_q, clr_d;
  logic [6:0] end_q, end_d, start_q, start_d, idx_q, idx_d;
  logic [1:0] nb_q, nb_d;
  logic [7:0] ba_q, ba_d, bb_q, bb_d;
  logic ov_q, ov_d;
  ldf_pkg::out_item_t od_q, od_d;

  logic wwe, swe, twe;
  logic [ldf_pkg::AddrW-1:0] wwa, wra, swa, sra, base;
  logic [7:0] wwd, swd, wrd, srd, twd, trd;
  logic [7:0] twa, tra, tra_q;
  logic [6:0] rd_col;
  logic [6:0] cnt;

  assign base = ldf_pkg::AddrW'(cmd_q.line * ldf_pkg::Cols);
  assign cnt = end_q - start_q;

  ldf_ram #(.Width(8), .Depth(ldf_pkg::Cells)) u_want (
    .clk_i, .we_i(wwe), .waddr_i(wwa), .wdata_i(wwd), .raddr_i(wra), .rdata_o(wrd));
  ldf_ram #(.Width(8), .Depth(ldf_pkg::Cells)) u_shown (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));
  ldf_ram #(.Width(8), .Depth(256)) u_tab (
    .clk_i, .we_i(twe), .waddr_i(twa), .wdata_i(twd), .raddr_i(tra), .rdata_o(trd));

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    clr_d = clr_q;
    end_d = end_q;
    start_d = start_q;
    idx_d = idx_q;
    nb_d = nb_q;
    ba_d = ba_q;
    bb_d = bb_q;
    ov_d = ov_q;
    od_d = od_q;
    cmd_pop_o = 1'b0;
    wwe = 1'b0;
    wwa = ldf_pkg::AddrW'(cmd_i.line * ldf_pkg::Cols) + ldf_pkg::AddrW'(cmd_i.col);
    wwd = cmd_i.value;
    swe = 1'b0;
    swa = base + ldf_pkg::AddrW'(idx_q);
    swd = wrd;
    twe = 1'b0;
    twa = cmd_i.col;
    twd = cmd_i.value;
    // table lookup address holds so a stalled byte reads back unchanged
    tra = tra_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      StClear: begin
        wwe = 1'b1;
        wwa = clr_q;
        wwd = '0;
        swe = 1'b1;
        swa = clr_q;
        swd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == ldf_pkg::AddrW'(ldf_pkg::Cells - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.cmd)
            ldf_pkg::CmdCell: wwe = 1'b1;
            ldf_pkg::CmdTable: twe = 1'b1;
            default: begin
              idx_d = 7'(ldf_pkg::Cols - 1);
              end_d = 7'(ldf_pkg::Cols);
              state_d = StEndRd;
            end
          endcase
        end
      end
      StEndRd: state_d = StEndCk;
      StEndCk: begin
        if (wrd != srd || end_q == 7'd0 || idx_q == 7'd0) begin
          if (wrd == srd) end_d = 7'd0;
          else end_d = idx_q + 7'd1;
          start_d = 7'd0;
          idx_d = 7'd0;
          state_d = StStRd;
          if (wrd == srd) begin
            idx_d = 7'd0;
          end
        end else begin
          idx_d = idx_q - 7'd1;
          state_d = StEndRd;
        end
      end
      StStRd: begin
        if (start_q >= end_q) state_d = StCpRd;
        else state_d = StStCk;
      end
      StStCk: begin
        if (wrd != srd) state_d = StCpRd;
        else begin
          start_d = start_q + 7'd1;
          idx_d = idx_q + 7'd1;
          state_d = StStRd;
        end
      end
      StCpRd: begin
        // copy loop: idx walks the span
        if (cnt == 7'd0 && !cmd_q.force_send) state_d = StIdle;
        else if (idx_q >= end_q) begin
          state_d = StOut;
        end else state_d = StCpWr;
        if (idx_q == start_q) begin
          nb_d = 2'd0;
          ba_d = '0;
          bb_d = '0;
        end
      end
      StCpWr: begin
        // wanted byte now valid: write shown, look up translation
        swe = 1'b1;
        tra = wrd;
        idx_d = idx_q + 7'd1;
        state_d = StOut;
      end
      StOut: begin
        // collect translated byte, emit when pair complete or span done
        if (nb_q != 2'd3) begin
          if (idx_q > start_q && nb_q < 2'd2) begin
            if (nb_q == 2'd0) ba_d = trd;
            else bb_d = trd;
            nb_d = nb_q + 2'd1;
          end
          if (nb_d == 2'd2 || idx_q >= end_q) nb_d = (nb_d == 2'd0) ? 2'd0 : nb_d;
        end
        if ((nb_d == 2'd2 || idx_q >= end_q)) begin
          if (!ov_q || !out_stall_i) begin
            ov_d = 1'b1;
            od_d.line_num = 5'(cmd_q.line + 1'b1);
            od_d.cursor_pos = cmd_q.cpos;
            od_d.start_col = start_q + 7'd1;
            od_d.span_count = cnt;
            od_d.byte_a = nb_d >= 2'd1 ? ba_d : 8'd0;
            od_d.byte_b = nb_d == 2'd2 ? bb_d : 8'd0;
            od_d.bytes_valid = nb_d;
            od_d.last = idx_q >= end_q;
            nb_d = 2'd0;
            ba_d = '0;
            bb_d = '0;
            state_d = (idx_q >= end_q) ? StIdle : StCpRd;
          end else begin
            // hold pair until output frees; keep collected bytes
            state_d = StOut;
            nb_d = nb_d;
            if (idx_q > start_q) idx_d = idx_q;
          end
        end else state_d = StCpRd;
        if (state_d == StOut) begin
          // avoid recounting a byte while waiting
          idx_d = idx_q;
          nb_d = nb_q;
          ba_d = ba_q;
          bb_d = bb_q;
          if (nb_q < 2'd2 && idx_q > start_q && !(nb_q == 2'd2)) begin
            nb_d = nb_q;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // ram read addresses follow next index
  always_comb begin
    rd_col = idx_d;
    wra = base + ldf_pkg::AddrW'(rd_col);
    sra = base + ldf_pkg::AddrW'(rd_col);
    if (state_q == StIdle) begin
      wra = ldf_pkg::AddrW'(cmd_i.line * ldf_pkg::Cols) + ldf_pkg::AddrW'(idx_d);
      sra = wra;
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      ov_q <= 1'b0;
      nb_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      nb_q <= nb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    end_q <= end_d;
    start_q <= start_d;
    idx_q <= idx_d;
    ba_q <= ba_d;
    bb_q <= bb_d;
    od_q <= od_d;
    tra_q <= tra;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/line_diff_update_framer_top.sv =====
// line_diff_update_framer_top: front classifier, command queue, scan/frame engine
// depends on ldf_pkg, ldf_front, ldf_queue, ldf_back, ldf_ram
// a send scans the line from the right for the span end, then from the left for its start,
// then copies and translates each span cell and emits results in pairs
// four commands queue between front and back
// after reset a clearing pass zeroes both screens; items wait
`default_nettype none
module line_diff_update_framer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ldf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ldf_pkg::out_item_t      out_data_o
);
  logic          cmd_valid, q_full, q_empty, q_pop;
  ldf_pkg::cmd_t cmd, q_data;

  ldf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_full_i(q_full), .cmd_o(cmd));

  ldf_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_valid), .push_data_i(cmd), .full_o(q_full),
    .empty_o(q_empty), .pop_i(q_pop), .pop_data_o(q_data));

  ldf_back u_back (
    .clk_i, .rst_ni, .cmd_empty_i(q_empty), .cmd_i(q_data), .cmd_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_data_o);
endmodule
`default_nettype wire

// ===== verif/line_diff_update_framer_top_test.sv =====
// line_diff_update_framer_top_test: self-checking bench for the line difference framer
// depends on ldf_pkg and line_diff_update_framer_top; predicts frames and checks them in order
`timescale 1ns / 1ps
`default_nettype none

module line_diff_update_framer_top_test;

  // screen and table shadow with frame prediction
  class frame_board;
    logic [7:0]          wanted [ldf_pkg::Rows*ldf_pkg::Cols];
    logic [7:0]          shown [ldf_pkg::Rows*ldf_pkg::Cols];
    logic [7:0]          xlat [256];
    int unsigned         cur_row;
    int unsigned         cur_col;
    int unsigned         cur_line;
    ldf_pkg::out_item_t  frames_q [$];
    int                  errors;
    int                  checked;

    function void clear();
      foreach (wanted[i]) begin
        wanted[i] = 0;
        shown[i] = 0;
      end
      foreach (xlat[i]) xlat[i] = 0;
      cur_row = ldf_pkg::Rows;
      cur_col = ldf_pkg::Cols;
      cur_line = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void send_line(int unsigned ln, bit force_send);
      int unsigned en, st, cnt, nres, cpos, left, k, b;
      ldf_pkg::out_item_t o;
      en = ldf_pkg::Cols;
      st = 0;
      while (en > 0 && wanted[ln*ldf_pkg::Cols+en-1] == shown[ln*ldf_pkg::Cols+en-1]) en--;
      while (st < en && wanted[ln*ldf_pkg::Cols+st] == shown[ln*ldf_pkg::Cols+st]) st++;
      cnt = en - st;
      if (cnt == 0 && !force_send) return;
      for (int i = st; i < en; i++) shown[ln*ldf_pkg::Cols+i] = wanted[ln*ldf_pkg::Cols+i];
      cpos = (ln == cur_row) ? cur_col + 1 : 0;
      nres = (cnt + 1) / 2;
      if (nres == 0) nres = 1;
      for (k = 0; k < nres; k++) begin
        b = ln*ldf_pkg::Cols + st + 2*k;
        left = (cnt == 0) ? 0 : cnt - 2*k;
        o.line_num = 5'(ln + 1);
        o.cursor_pos = 7'(cpos);
        o.start_col = 7'(st + 1);
        o.span_count = 7'(cnt);
        o.byte_a = (left >= 1) ? xlat[shown[b]] : 8'd0;
        o.byte_b = (left >= 2) ? xlat[shown[b+1]] : 8'd0;
        o.bytes_valid = (left >= 2) ? 2'd2 : 2'(left);
        o.last = (k + 1 == nres);
        frames_q.push_back(o);
      end
    endfunction

    function void note_request(ldf_pkg::in_item_t it);
      int unsigned r, c;
      case (it.req_type)
        ldf_pkg::ReqWriteCell: if (it.row < ldf_pkg::Rows && it.column < ldf_pkg::Cols)
          wanted[it.row*ldf_pkg::Cols+it.column] = it.value;
        ldf_pkg::ReqWriteTable: xlat[it.column] = it.value;
        ldf_pkg::ReqSetCursor: begin
          r = (it.row > ldf_pkg::Rows) ? ldf_pkg::Rows : (it.row < 1 ? 1 : it.row);
          c = (it.column > ldf_pkg::Cols) ? ldf_pkg::Cols : (it.column < 1 ? 1 : it.column);
          if (r - 1 != cur_row || c - 1 != cur_col) begin
            cur_row = r - 1;
            cur_col = c - 1;
            send_line(cur_row, 1);
          end
        end
        ldf_pkg::ReqLine: begin
          if (it.line_number == 0) begin
            if (cur_row < ldf_pkg::Rows) send_line(cur_row, 1);
          end else if (it.line_number <= ldf_pkg::Rows) begin
            cur_line = it.line_number - 1;
            send_line(cur_line, 0);
          end
        end
        ldf_pkg::ReqRefresh: send_line(cur_line, 0);
        default: ;
      endcase
    endfunction

    function void check_frame(ldf_pkg::out_item_t got);
      ldf_pkg::out_item_t exp;
      if (frames_q.size() == 0) begin
        $display("%0t: unexpected frame result %p", $time, got);
        errors++;
        return;
      end
      exp = frames_q.pop_front();
      checked++;
      if (got !== exp) begin
        $display("%0t: frame mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                in_valid_i = 0;
  logic                in_stall_o;
  ldf_pkg::in_item_t   in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 0;
  ldf_pkg::out_item_t  out_data_o;

  frame_board board;
  int         idle_pct = 32;
  int         accepted_cnt = 0;
  int         quiet_cycles = 0;
  localparam int QuietLimit = 40000;
  // character codes stay below this so only a small table needs filling
  localparam int CharCodes = 16;

  line_diff_update_framer_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  // result side: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_frame(out_data_o);
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog on accept-free cycles
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // drive one request and wait for it to be taken
  task automatic push_request(ldf_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(it);
    accepted_cnt++;
  endtask

  task automatic mk(input logic [2:0] rt, input logic [7:0] r, c, v, ln);
    ldf_pkg::in_item_t it;
    it.req_type = rt;
    it.row = r;
    it.column = c;
    it.value = v;
    it.line_number = ln;
    push_request(it);
  endtask

  // random request mix: writes to a few rows make up the largest share, then sends
  task automatic random_request();
    int unsigned pick;
    logic [7:0] rr;
    pick = $urandom_range(99);
    rr = 8'($urandom_range(2));
    if (pick < 45)
      mk(ldf_pkg::ReqWriteCell, ($urandom_range(9) == 0) ? 8'($urandom) : rr,
         ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ldf_pkg::Cols-1)),
         8'($urandom_range(CharCodes-1)), 8'($urandom));
    else if (pick < 55)
      mk(ldf_pkg::ReqWriteTable, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 67)
      mk(ldf_pkg::ReqSetCursor, ($urandom_range(4) == 0) ? 8'($urandom) : rr + 1,
         8'($urandom_range(ldf_pkg::Cols + 2)), 8'($urandom), 8'($urandom));
    else if (pick < 85)
      mk(ldf_pkg::ReqLine, 8'($urandom), 8'($urandom), 8'($urandom),
         ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
    else mk(3'($urandom_range(4, 7)), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // fill every table entry a cell can hold so no unwritten entry is read
    idle_pct = 0;
    for (int i = 0; i < CharCodes; i++) begin
      mk(ldf_pkg::ReqWriteTable, 8'hff, 8'(i), 8'(i ^ 8'h5a), 8'h00);
    end
    idle_pct = 32;

    // directed: cursor row before set, extremes, header-only, ignored cases
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd0);
    mk(ldf_pkg::ReqWriteCell, 8'd0, 8'd0, 8'h0f, 8'hff);
    mk(ldf_pkg::ReqWriteCell, 8'd24, 8'd79, 8'h01, 8'd0);
    mk(ldf_pkg::ReqWriteCell, 8'd25, 8'd0, 8'h11, 8'd0);
    mk(ldf_pkg::ReqWriteCell, 8'd0, 8'd80, 8'h11, 8'd0);
    mk(ldf_pkg::ReqWriteCell, 8'hff, 8'hff, 8'h22, 8'd0);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd1);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd25);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd26);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'hff);
    mk(ldf_pkg::ReqRefresh, 8'd0, 8'd0, 8'd0, 8'd0);
    mk(ldf_pkg::ReqSetCursor, 8'd0, 8'd0, 8'd0, 8'd0);
    mk(ldf_pkg::ReqSetCursor, 8'd1, 8'd1, 8'd0, 8'd0);
    mk(ldf_pkg::ReqSetCursor, 8'hff, 8'hff, 8'd0, 8'd0);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd0);
    for (int c = 0; c < ldf_pkg::Cols; c += 9)
      mk(ldf_pkg::ReqWriteCell, 8'd3, 8'(c), 8'(c / 9 + 1), 8'd0);
    mk(ldf_pkg::ReqLine, 8'd0, 8'd0, 8'd0, 8'd4);
    mk(3'd5, 8'd0, 8'd0, 8'd0, 8'd0);
    mk(3'd7, 8'hff, 8'hff, 8'hff, 8'hff);

    // random part with a stretch of no idling in the middle
    for (int n = 0; n < 167; n++) begin
      idle_pct = (n >= 60 && n < 110) ? 0 : 32;
      random_request();
    end
    in_valid_i <= 1'b0;
    idle_pct = 32;

    while (board.frames_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("covered %0d requests and %0d frame results across writes, cursor and sends",
             accepted_cnt, board.checked);
    if (board.errors == 0 && board.frames_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
